// ===== hw/rtl/crc8bc_pkg.sv =====
// Types, constants and the byte update function of the CRC-8 block checker.
`timescale 1ns / 1ps
`default_nettype none

package crc8bc_pkg;

  localparam int unsigned CRC_W = 8;

  typedef logic [CRC_W-1:0] crc_t;

  localparam crc_t POLY_RESET = 8'hD5;

  // Accepted request as it sits in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_block;
    logic [7:0] expected_checksum;
    logic       first_of_file;
  } in_req_t;

  // Result as it sits in the output register.
  typedef struct packed {
    crc_t computed_crc;
    logic block_matches;
    logic file_ok;
  } out_res_t;

  // Fold one byte into the CRC, MSB first, eight shift steps.
  function automatic crc_t crc_absorb(crc_t crc, logic [7:0] data, crc_t poly);
    crc_t c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crc8bc_in_if.sv =====
// Input channel interface: data bytes with block and file markers.
`timescale 1ns / 1ps
`default_nettype none

interface crc8bc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_block;
  logic [7:0] expected_checksum;
  logic       first_of_file;

  modport source (output valid, output data_byte, output last_in_block,
                  output expected_checksum, output first_of_file, input ready);
  modport sink (input valid, input data_byte, input last_in_block,
                input expected_checksum, input first_of_file, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/crc8bc_out_if.sv =====
// Result channel interface: block CRC and match status.
`timescale 1ns / 1ps
`default_nettype none

interface crc8bc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] computed_crc;
  logic       block_matches;
  logic       file_ok;

  modport source (output valid, output computed_crc, output block_matches,
                  output file_ok, input ready);
  modport sink (input valid, input computed_crc, input block_matches,
                input file_ok, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/crc8_block_checker_core.sv =====
// Top level of the CRC-8 block checker: input register, CRC update, result register.
//
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      data_byte, last_in_block, expected_checksum, first_of_file
//  out_ch   out  valid/ready      computed_crc, block_matches, file_ok
//  cfg      in   cfg_we           cfg_wdata (generator polynomial, low 8 bits)
//
// One request per cycle is accepted unless a block-ending byte waits on a stalled result;
// a block's last byte passes the input register, then its result the result register. The eight-step XOR-shift
// update sits between the two registers. Reset clears the CRC, the mismatch flag,
// both valid flags and loads the polynomial 0xD5. A stalled result holds only the
// requests that end a block; other bytes keep flowing past it.
`timescale 1ns / 1ps
`default_nettype none

module crc8_block_checker_core (
  input  wire                 clk,
  input  wire                 rst_n,
  crc8bc_in_if.sink           in_ch,
  crc8bc_out_if.source        out_ch,
  input  wire                 cfg_we,
  input  wire crc8bc_pkg::crc_t cfg_wdata
);
  import crc8bc_pkg::*;

  crc_t     poly_r;
  crc_t     crc_r;
  crc_t     crc_nxt;
  logic     mismatch_r;
  logic     mismatch_nxt;
  logic     s1_valid_r;
  in_req_t  s1_req_r;
  logic     out_valid_r;
  out_res_t out_res_r;
  out_res_t out_res_nxt;
  logic     s1_adv;
  logic     in_fire;
  crc_t     crc_base;
  logic     match;

  // A byte that ends no block never needs the result register.
  assign s1_adv  = s1_valid_r && (!s1_req_r.last_in_block || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    crc_base     = s1_req_r.first_of_file ? '0 : crc_r;
    crc_nxt      = crc_absorb(crc_base, s1_req_r.data_byte, poly_r);
    match        = (crc_nxt == s1_req_r.expected_checksum);
    mismatch_nxt = (s1_req_r.first_of_file ? 1'b0 : mismatch_r)
                   | (s1_req_r.last_in_block & ~match);
    out_res_nxt.computed_crc  = crc_nxt;
    out_res_nxt.block_matches = match;
    out_res_nxt.file_ok       = ~mismatch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r      <= POLY_RESET;
      crc_r       <= '0;
      mismatch_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        poly_r <= cfg_wdata;
      end
      if (s1_adv) begin
        crc_r      <= crc_nxt;
        mismatch_r <= mismatch_nxt;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv && s1_req_r.last_in_block) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.data_byte         <= in_ch.data_byte;
      s1_req_r.last_in_block     <= in_ch.last_in_block;
      s1_req_r.expected_checksum <= in_ch.expected_checksum;
      s1_req_r.first_of_file     <= in_ch.first_of_file;
    end
    if (s1_adv && s1_req_r.last_in_block) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.computed_crc  = out_res_r.computed_crc;
  assign out_ch.block_matches = out_res_r.block_matches;
  assign out_ch.file_ok       = out_res_r.file_ok;

endmodule

`default_nettype wire

// ===== hw/rtl/crc8bc_checker.sv =====
// Port-level assertions for the CRC-8 block checker and their bind.
`timescale 1ns / 1ps
`default_nettype none

module crc8bc_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_computed_crc,
  input wire       out_block_matches,
  input wire       out_file_ok
);

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_computed_crc)
      && $stable(out_block_matches) && $stable(out_file_ok))
    else $error("stalled result changed or dropped");

  // A failed block always clears the file status.
  a_mismatch_file: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_block_matches |-> !out_file_ok)
    else $error("file_ok set on a mismatching block");

  // Input back-pressure comes only from a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // Drop any result on reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind crc8_block_checker_core crc8bc_checker u_crc8bc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_computed_crc (out_ch.computed_crc),
  .out_block_matches(out_ch.block_matches),
  .out_file_ok      (out_ch.file_ok)
);

`default_nettype wire

// ===== sim/crc8_block_checker_core_test.sv =====
// Self-checking testbench for the CRC-8 block checker core: directed and random request streams.
`timescale 1ns / 1ps

module crc8_block_checker_core_test;
  import crc8bc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  logic cfg_we;
  crc_t cfg_wdata;

  crc8bc_in_if  in_ch ();
  crc8bc_out_if out_ch ();

  crc8_block_checker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted state of the checker.
  crc_t     crc_model;
  logic     mismatch_model;
  crc_t     poly_model;
  out_res_t block_results_due[$];
  out_res_t want;

  int send_idle_pct;
  int recv_stall_pct;
  logic out_hold;

  int cycle_count;
  int error_count;
  int requests_sent;
  int results_checked;
  int bad_blocks;
  int poly_writes;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               block_results_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Fold one byte into the CRC, one bit per step, with a ninth bit for the carry out.
  function automatic crc_t crc_fold(crc_t crc, logic [7:0] data, crc_t poly);
    logic [8:0] acc;
    acc = {1'b0, crc ^ data};
    for (int i = 0; i < 8; i++) begin
      acc = acc << 1;
      if (acc[8]) begin
        acc[7:0] = acc[7:0] ^ poly;
      end
      acc[8] = 1'b0;
    end
    return acc[7:0];
  endfunction

  // CRC that a block ending on this byte will report.
  function automatic crc_t crc_if_last(logic [7:0] data, logic first);
    return crc_fold(first ? 8'h00 : crc_model, data, poly_model);
  endfunction

  function automatic void absorb_request(logic [7:0] data, logic last, logic [7:0] chk,
                                         logic first);
    out_res_t res;
    if (first) begin
      crc_model = 8'h00;
      mismatch_model = 1'b0;
    end
    crc_model = crc_fold(crc_model, data, poly_model);
    if (last) begin
      res.computed_crc  = crc_model;
      res.block_matches = (crc_model == chk);
      if (!res.block_matches) begin
        mismatch_model = 1'b1;
        bad_blocks++;
      end
      res.file_ok = !mismatch_model;
      block_results_due.push_back(res);
    end
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp_val);
    $display("MISMATCH at cycle %0d: %s got %0h want %0h", cycle_count, what, got, exp_val);
    error_count++;
  endtask

  task automatic check_field(string what, logic [7:0] got, logic [7:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch(what, got, exp_val);
    end
  endtask

  // Result side: random stalls, long hold-off on request, compare in order.
  always @(posedge clk) begin
    out_ch.ready <= !out_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (block_results_due.size() == 0) begin
        report_mismatch("unexpected result crc", out_ch.computed_crc, 8'h00);
      end else begin
        want = block_results_due.pop_front();
        check_field("computed_crc", out_ch.computed_crc, want.computed_crc);
        check_field("block_matches", 8'(out_ch.block_matches), 8'(want.block_matches));
        check_field("file_ok", 8'(out_ch.file_ok), 8'(want.file_ok));
        results_checked++;
      end
    end
  end

  task automatic send_item(logic [7:0] data, logic last, logic [7:0] chk, logic first);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.data_byte         <= data;
    in_ch.last_in_block     <= last;
    in_ch.expected_checksum <= chk;
    in_ch.first_of_file     <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_request(data, last, chk, first);
    requests_sent++;
  endtask

  // Random bytes; the closing checksum is right or deliberately wrong.
  task automatic send_block(int len, logic first, logic good);
    logic [7:0] data;
    logic [7:0] chk;
    logic fst;
    for (int i = 0; i < len; i++) begin
      data = 8'($urandom_range(0, 255));
      fst = first && (i == 0);
      if (i == len - 1) begin
        chk = crc_if_last(data, fst);
        if (!good) begin
          chk = chk ^ 8'($urandom_range(1, 255));
        end
        send_item(data, 1'b1, chk, fst);
      end else begin
        send_item(data, 1'b0, 8'($urandom_range(0, 255)), fst);
      end
    end
  endtask

  // Drop valid and hold until every result is in, then let the pipe settle.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (block_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_poly(crc_t p);
    wait_drain();
    cfg_wdata <= p;
    cfg_we    <= 1'b1;
    @(posedge clk);
    poly_model = p;
    cfg_we <= 1'b0;
    poly_writes++;
  endtask

  task automatic run_random(int n, int sidle, int rstall);
    int start;
    int len;
    start = requests_sent;
    send_idle_pct = sidle;
    recv_stall_pct <= rstall;
    while (requests_sent - start < n) begin
      if ($urandom_range(0, 99) < 10) begin
        // stray request: any flag combination, checksum unrelated to the CRC
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        send_block(len, $urandom_range(0, 19) == 0, $urandom_range(0, 99) < 80);
      end
    end
    wait_drain();
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    send_item(8'h00, 1'b1, crc_if_last(8'h00, 1'b1), 1'b1);
    send_item(8'hFF, 1'b1, crc_if_last(8'hFF, 1'b1), 1'b1);
    send_item(8'h80, 1'b0, 8'hFF, 1'b1);
    send_item(8'h01, 1'b1, crc_if_last(8'h01, 1'b0), 1'b0);
    // wrong checksum, then the flag must stick across good blocks
    send_item(8'h5A, 1'b1, crc_if_last(8'h5A, 1'b0) ^ 8'hFF, 1'b0);
    send_item(8'h00, 1'b1, crc_if_last(8'h00, 1'b0), 1'b0);
    send_item(8'h7F, 1'b0, 8'h00, 1'b0);
    send_item(8'hFE, 1'b1, crc_if_last(8'hFE, 1'b0), 1'b0);
    // first and last on one request clears before the compare
    send_item(8'hA5, 1'b1, crc_if_last(8'hA5, 1'b1), 1'b1);
    // clear in the middle of a block
    send_item(8'hC3, 1'b0, 8'hAA, 1'b0);
    send_item(8'h3C, 1'b0, 8'h55, 1'b1);
    send_item(8'hFF, 1'b1, crc_if_last(8'hFF, 1'b0), 1'b0);
    send_item(8'h00, 1'b1, 8'h00, 1'b0);
    send_item(8'hFF, 1'b1, 8'hFF, 1'b0);
    send_block(8, 1'b1, 1'b1);
    send_block(4, 1'b0, 1'b0);
    wait_drain();
  endtask

  task automatic test_poly_extremes();
    set_poly(8'h00);
    run_random(20, 0, 0);
    set_poly(8'hFF);
    run_random(20, 0, 0);
    set_poly(POLY_RESET);
    run_random(20, 0, 0);
  endtask

  task automatic test_random_no_idle();
    set_poly(8'h31);
    run_random(350, 0, 0);
  endtask

  task automatic test_sender_idle();
    set_poly(8'h07);
    run_random(300, 88, 0);
  endtask

  task automatic test_receiver_stall();
    set_poly(8'h9B);
    run_random(300, 0, 88);
  endtask

  task automatic test_both_idle();
    set_poly(8'($urandom_range(0, 255)));
    run_random(300, 30, 30);
  endtask

  // Hold the result side for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    set_poly(POLY_RESET);
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    fork
      begin
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 30; i++) begin
      send_block($urandom_range(1, 4), 1'b0, $urandom_range(0, 3) != 0);
    end
    wait_drain();
  endtask

  initial begin
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_wdata               = POLY_RESET;
    in_ch.valid             = 1'b0;
    in_ch.data_byte         = 8'h00;
    in_ch.last_in_block     = 1'b0;
    in_ch.expected_checksum = 8'h00;
    in_ch.first_of_file     = 1'b0;
    out_ch.ready            = 1'b0;
    out_hold                = 1'b0;
    send_idle_pct           = 0;
    recv_stall_pct          = 0;
    cycle_count             = 0;
    error_count             = 0;
    requests_sent           = 0;
    results_checked         = 0;
    bad_blocks              = 0;
    poly_writes             = 0;
    crc_model               = 8'h00;
    mismatch_model          = 1'b0;
    poly_model              = POLY_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_poly_extremes();
    test_random_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_output_backpressure();

    wait_drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests under %0d polynomial writes; checked %0d block results,",
             requests_sent, poly_writes, results_checked);
    $display("%0d of them with a wrong checksum, across idle, stall and hold-off phases.",
             bad_blocks);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
